/* hw/rtl/smbb_pkg.sv */
// ----------------------------------------------------------------------------
// smbb_pkg: shared types and constants for the scaled mono bitmap blitter
// Register indexes, reset values, field widths, sequencer states and the
// request/response bundles of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package smbb_pkg;

	localparam int unsigned BITMAP_BYTES_DEF   = 512;
	localparam int unsigned MAX_DEST_WIDTH_DEF = 64;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;

	localparam logic [6:0]  RST_SOURCE_WIDTH  = 7'd8;
	localparam logic [6:0]  RST_SOURCE_HEIGHT = 7'd8;
	localparam logic [6:0]  RST_DEST_WIDTH    = 7'd8;
	localparam logic [10:0] RST_DEST_HEIGHT   = 11'd8;
	localparam logic [12:0] RST_FRAME_WIDTH   = 13'd640;
	localparam logic [12:0] RST_FRAME_HEIGHT  = 13'd480;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_RENDER = 1'b1;

	localparam int unsigned IN_DATA_W  = 88;
	localparam int unsigned OUT_DATA_W = 56;

	// 8.16 step arithmetic
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned DIV_NUM_W = 23;
	localparam int unsigned DIV_DEN_W = 11;
	localparam int unsigned STEP_W    = 24;
	localparam int unsigned ACC_W     = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVX,
		ST_DIVY,
		ST_ROWY,
		ST_ROWB,
		ST_ROWA,
		ST_COLRD,
		ST_COLWR
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/smbb_ram.sv */
// ----------------------------------------------------------------------------
// smbb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smbb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 512,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/smbb_div.sv */
// ----------------------------------------------------------------------------
// smbb_div: shared restoring divider
// One quotient bit per cycle; done pulses once the quotient is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module smbb_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire smbb_pkg::div_req_t req,
	output smbb_pkg::div_rsp_t      rsp
);

	localparam int unsigned NW = smbb_pkg::DIV_NUM_W;
	localparam int unsigned DW = smbb_pkg::DIV_DEN_W;
	localparam int unsigned CW = $clog2(NW);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

`default_nettype wire

/* hw/rtl/scaled_mono_bitmap_blit.sv */
// ----------------------------------------------------------------------------
// scaled_mono_bitmap_blit: nearest-neighbor scaled 1bpp bitmap blitter
// Load beats store one bitmap byte each. A render beat runs both 8.16 step
// divisions through one shared restoring divider, then three setup states
// (ROWY, ROWB, ROWA), then for each destination column a RAM read state and a
// beat-out state that waits while the output stalls, then returns to idle.
// Input beats are accepted only in idle. A render beat that yields no columns
// is taken in idle and produces no beats. Reset clears control state and
// loads the configuration reset values; bitmap RAM contents are kept as they
// were.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_mono_bitmap_blit #(
	parameter int unsigned BITMAP_BYTES   = smbb_pkg::BITMAP_BYTES_DEF,
	parameter int unsigned MAX_DEST_WIDTH = smbb_pkg::MAX_DEST_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [smbb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [smbb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// byte_index, byte_value, row_index, origin_x, origin_y, draw_color
	input  wire logic [smbb_pkg::IN_DATA_W-1:0]    s_tdata,
	// mode
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// pixel_address, pixel_color
	output logic [smbb_pkg::OUT_DATA_W-1:0]        m_tdata,
	// write_pixel
	output logic                                   m_tuser,
	output logic                                   m_tlast
);

	localparam int unsigned AW  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
	localparam int unsigned CW  = $clog2(MAX_DEST_WIDTH + 1);
	localparam int unsigned SW  = smbb_pkg::STEP_W;
	localparam int unsigned ACW = smbb_pkg::ACC_W;
	localparam int unsigned FW  = smbb_pkg::FRAC_W;
	localparam logic [12:0] BYTES_LIM = 13'(BITMAP_BYTES);
	localparam logic [6:0]  MAX_COLS  = 7'(MAX_DEST_WIDTH);

	// configuration
	logic [6:0]  src_w_q, src_h_q, dst_w_q;
	logic [10:0] dst_h_q;
	logic [12:0] frm_w_q, frm_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= smbb_pkg::RST_SOURCE_WIDTH;
			src_h_q <= smbb_pkg::RST_SOURCE_HEIGHT;
			dst_w_q <= smbb_pkg::RST_DEST_WIDTH;
			dst_h_q <= smbb_pkg::RST_DEST_HEIGHT;
			frm_w_q <= smbb_pkg::RST_FRAME_WIDTH;
			frm_h_q <= smbb_pkg::RST_FRAME_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				smbb_pkg::REG_SOURCE_WIDTH:  src_w_q <= cfg_data[6:0];
				smbb_pkg::REG_SOURCE_HEIGHT: src_h_q <= cfg_data[6:0];
				smbb_pkg::REG_DEST_WIDTH:    dst_w_q <= cfg_data[6:0];
				smbb_pkg::REG_DEST_HEIGHT:   dst_h_q <= cfg_data[10:0];
				smbb_pkg::REG_FRAME_WIDTH:   frm_w_q <= cfg_data;
				smbb_pkg::REG_FRAME_HEIGHT:  frm_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input beat fields
	logic        in_mode;
	logic [8:0]  in_byte_index;
	logic [7:0]  in_byte_value;
	logic [9:0]  in_row;
	logic [11:0] in_ox, in_oy;
	logic [31:0] in_color;

	assign in_mode       = s_tuser;
	assign in_byte_index = s_tdata[8:0];
	assign in_byte_value = s_tdata[16:9];
	assign in_row        = s_tdata[26:17];
	assign in_ox         = s_tdata[38:27];
	assign in_oy         = s_tdata[50:39];
	assign in_color      = s_tdata[82:51];

	logic in_acc;
	logic render_ok;
	logic [6:0] cols_w;
	logic [12:0] ld_addr_w;

	assign in_acc    = s_tvalid && s_tready;
	assign render_ok = ({1'b0, in_row} < dst_h_q) && (dst_w_q != '0);
	assign cols_w    = (dst_w_q > MAX_COLS) ? MAX_COLS : dst_w_q;
	assign ld_addr_w = {4'b0, in_byte_index};

	// sequencer
	smbb_pkg::state_t state_q, state_d;
	smbb_pkg::div_req_t div_req;
	smbb_pkg::div_rsp_t div_rsp;

	logic          out_load;
	logic          ram_we;
	logic          last_col;

	logic [CW-1:0]  cols_q, col_q;
	logic [9:0]     row_q;
	logic [11:0]    ox_q, oy_q;
	logic [31:0]    color_q;
	logic [SW-1:0]  xstep_q, ystep_q;
	logic [6:0]     src_y_q;
	logic [12:0]    dst_row_q, dst_col_q;
	logic [13:0]    row_base_q;
	logic [23:0]    addr_q;
	logic           row_ok_q;
	logic [ACW-1:0] acc_q;

	assign last_col = (col_q == cols_q - CW'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smbb_pkg::ST_IDLE: begin
				if (in_acc && in_mode == smbb_pkg::MODE_RENDER && render_ok) begin
					state_d = smbb_pkg::ST_DIVX;
				end
			end
			smbb_pkg::ST_DIVX: if (div_rsp.done) state_d = smbb_pkg::ST_DIVY;
			smbb_pkg::ST_DIVY: if (div_rsp.done) state_d = smbb_pkg::ST_ROWY;
			smbb_pkg::ST_ROWY: state_d = smbb_pkg::ST_ROWB;
			smbb_pkg::ST_ROWB: state_d = smbb_pkg::ST_ROWA;
			smbb_pkg::ST_ROWA: state_d = smbb_pkg::ST_COLRD;
			smbb_pkg::ST_COLRD: state_d = smbb_pkg::ST_COLWR;
			smbb_pkg::ST_COLWR: begin
				if (out_load) begin
					state_d = last_col ? smbb_pkg::ST_IDLE : smbb_pkg::ST_COLRD;
				end
			end
			default: state_d = smbb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {src_w_q, 16'b0};
		div_req.divisor  = {4'b0, dst_w_q};
		out_load         = 1'b0;
		ram_we           = 1'b0;
		unique case (state_q)
			smbb_pkg::ST_IDLE: begin
				s_tready      = 1'b1;
				div_req.start = in_acc && in_mode == smbb_pkg::MODE_RENDER && render_ok;
				ram_we        = in_acc && in_mode == smbb_pkg::MODE_LOAD &&
				                (ld_addr_w < BYTES_LIM);
			end
			smbb_pkg::ST_DIVX: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {src_h_q, 16'b0};
				div_req.divisor  = dst_h_q;
			end
			smbb_pkg::ST_COLWR: out_load = !m_tvalid || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smbb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	logic [33:0] y_prod;
	logic [13:0] bit_pos;
	logic [12:0] byte_pos;
	logic [25:0] addr_prod;
	logic [7:0]  ram_rdata;
	logic        bit_set;
	logic        wr_pix;

	assign y_prod    = {24'b0, row_q} * {10'b0, ystep_q};
	assign addr_prod = dst_row_q * frm_w_q;
	assign bit_pos   = row_base_q + {7'b0, acc_q[FW+6:FW]};
	assign byte_pos  = {2'b0, bit_pos[13:3]};
	assign bit_set   = (byte_pos < BYTES_LIM) && ram_rdata[3'd7 - bit_pos[2:0]];
	assign wr_pix    = bit_set && row_ok_q && (dst_col_q < frm_w_q);

	always_ff @(posedge clk) begin
		if (state_q == smbb_pkg::ST_IDLE && in_acc) begin
			cols_q  <= cols_w[CW-1:0];
			row_q   <= in_row;
			ox_q    <= in_ox;
			oy_q    <= in_oy;
			color_q <= in_color;
		end
		if (state_q == smbb_pkg::ST_DIVX && div_rsp.done) begin
			xstep_q <= {1'b0, div_rsp.quotient} + SW'(1);
		end
		if (state_q == smbb_pkg::ST_DIVY && div_rsp.done) begin
			ystep_q <= {1'b0, div_rsp.quotient} + SW'(1);
		end
		if (state_q == smbb_pkg::ST_ROWY) begin
			src_y_q   <= y_prod[FW+6:FW];
			dst_row_q <= {1'b0, oy_q} + {3'b0, row_q};
			dst_col_q <= {1'b0, ox_q};
			acc_q     <= '0;
			col_q     <= '0;
		end
		if (state_q == smbb_pkg::ST_ROWB) begin
			row_base_q <= src_y_q * src_w_q;
			row_ok_q   <= dst_row_q < frm_h_q;
		end
		if (state_q == smbb_pkg::ST_ROWA) begin
			addr_q <= addr_prod[23:0] + {12'b0, ox_q};
		end
		if (out_load) begin
			acc_q     <= acc_q + {7'b0, xstep_q};
			col_q     <= col_q + CW'(1);
			dst_col_q <= dst_col_q + 13'd1;
			addr_q    <= addr_q + 24'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser <= wr_pix;
			m_tlast <= last_col;
			m_tdata <= wr_pix ? {color_q, addr_q} : '0;
		end
	end

	smbb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	smbb_ram #(
		.WIDTH (8),
		.DEPTH (BITMAP_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ld_addr_w[AW-1:0]),
		.wdata (in_byte_value),
		.raddr (byte_pos[AW-1:0]),
		.rdata (ram_rdata)
	);

	a_beat_from_column: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == smbb_pkg::ST_COLWR))
		else $error("output beat raised outside column write");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("non-write beat carries address or color");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == smbb_pkg::ST_DIVX || state_q == smbb_pkg::ST_DIVY))
		else $error("divider finished outside a divide state");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smbb_pkg::ST_COLWR) |-> (col_q < cols_q))
		else $error("column index past column count");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != smbb_pkg::ST_IDLE) |-> !ram_we)
		else $error("bitmap write during render");

endmodule

`default_nettype wire

/* sim/blit_row_checker.sv */
// ----------------------------------------------------------------------------
// blit_row_checker: scoreboard for the scaled mono bitmap blitter
// Watches the register port and both stream channels. Keeps its own copy of
// the registers and the bitmap, sweeps every accepted render beat into the
// pixel beats it must produce, and compares each output beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module blit_row_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [smbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [smbb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	// byte_index, byte_value, row_index, origin_x, origin_y, draw_color
	input  wire logic [smbb_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode
	input  wire logic                            s_tuser,
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	// pixel_address, pixel_color
	input  wire logic [smbb_pkg::OUT_DATA_W-1:0] m_tdata,
	// write_pixel
	input  wire logic                            m_tuser,
	input  wire logic                            m_tlast,
	output int                                   errors,
	output int                                   pending
);

	typedef struct packed {
		logic        wr;
		logic [23:0] addr;
		logic [31:0] color;
		logic        last;
	} pixel_write_t;

	pixel_write_t writes_due[$];
	pixel_write_t want;
	logic [7:0]   bitmap[smbb_pkg::BITMAP_BYTES_DEF];
	logic [6:0]   src_w;
	logic [6:0]   src_h;
	logic [6:0]   dst_w;
	logic [10:0]  dst_h;
	logic [12:0]  frame_w;
	logic [12:0]  frame_h;
	int           mismatches = 0;

	function automatic void sweep_row(input logic [9:0] row, input logic [11:0] ox,
			input logic [11:0] oy, input logic [31:0] color);
		longint unsigned cols;
		longint unsigned xstep;
		longint unsigned ystep;
		longint unsigned src_y;
		longint unsigned src_x;
		longint unsigned bit_pos;
		longint unsigned byte_pos;
		longint unsigned dst_row;
		longint unsigned dst_col;
		longint unsigned full_addr;
		int              shift;
		logic            hit;
		pixel_write_t    px;
		cols = (dst_w > smbb_pkg::MAX_DEST_WIDTH_DEF) ? smbb_pkg::MAX_DEST_WIDTH_DEF : dst_w;
		if (row >= dst_h || cols == 0)
			return;
		xstep = src_w;
		xstep = ((xstep << smbb_pkg::FRAC_W) / dst_w) + 1;
		ystep = src_h;
		ystep = ((ystep << smbb_pkg::FRAC_W) / dst_h) + 1;
		src_y = row;
		src_y = (src_y * ystep) >> smbb_pkg::FRAC_W;
		dst_row = oy;
		dst_row = dst_row + row;
		for (longint unsigned j = 0; j < cols; j++) begin
			src_x = (j * xstep) >> smbb_pkg::FRAC_W;
			bit_pos = src_y * src_w + src_x;
			byte_pos = bit_pos >> 3;
			shift = 7 - int'(bit_pos & 7);
			hit = (byte_pos < smbb_pkg::BITMAP_BYTES_DEF) ? bitmap[byte_pos][shift] : 1'b0;
			dst_col = ox;
			dst_col = dst_col + j;
			px.wr = hit && dst_row < frame_h && dst_col < frame_w;
			full_addr = dst_row * frame_w + dst_col;
			px.addr = px.wr ? full_addr[23:0] : 24'd0;
			px.color = px.wr ? color : 32'd0;
			px.last = (j + 1 == cols);
			writes_due.push_back(px);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w = smbb_pkg::RST_SOURCE_WIDTH;
			src_h = smbb_pkg::RST_SOURCE_HEIGHT;
			dst_w = smbb_pkg::RST_DEST_WIDTH;
			dst_h = smbb_pkg::RST_DEST_HEIGHT;
			frame_w = smbb_pkg::RST_FRAME_WIDTH;
			frame_h = smbb_pkg::RST_FRAME_HEIGHT;
			writes_due.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					smbb_pkg::REG_SOURCE_WIDTH:  src_w = cfg_data[6:0];
					smbb_pkg::REG_SOURCE_HEIGHT: src_h = cfg_data[6:0];
					smbb_pkg::REG_DEST_WIDTH:    dst_w = cfg_data[6:0];
					smbb_pkg::REG_DEST_HEIGHT:   dst_h = cfg_data[10:0];
					smbb_pkg::REG_FRAME_WIDTH:   frame_w = cfg_data[12:0];
					smbb_pkg::REG_FRAME_HEIGHT:  frame_h = cfg_data[12:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == smbb_pkg::MODE_LOAD)
					bitmap[s_tdata[8:0]] = s_tdata[16:9];
				else
					sweep_row(s_tdata[26:17], s_tdata[38:27], s_tdata[50:39],
						s_tdata[82:51]);
			end
			if (m_tvalid && m_tready) begin
				if (writes_due.size() == 0) begin
					mismatches++;
					$display("%0t: expected none, got %0b %h %h %0b",
						$time, m_tuser, m_tdata[23:0], m_tdata[55:24], m_tlast);
				end else begin
					want = writes_due.pop_front();
					if (m_tuser !== want.wr || m_tdata[23:0] !== want.addr ||
							m_tdata[55:24] !== want.color || m_tlast !== want.last) begin
						mismatches++;
						$display("%0t: expected %0b %h %h %0b, got %0b %h %h %0b",
							$time, want.wr, want.addr, want.color, want.last,
							m_tuser, m_tdata[23:0], m_tdata[55:24], m_tlast);
					end
				end
			end
			pending <= writes_due.size();
			errors <= mismatches;
		end
	end

endmodule

`default_nettype wire

/* sim/tb_scaled_mono_bitmap_blit.sv */
// ----------------------------------------------------------------------------
// tb_scaled_mono_bitmap_blit: stimulus and verdict for the bitmap blitter
// Loads bitmap bytes and renders scaled rows under a series of register
// settings, from the smallest and largest sizes to zero and over-wide ones,
// with random gaps on both channels and one long output stall. Bytes that a
// render will sample are always loaded first. A checker scores every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_scaled_mono_bitmap_blit;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [smbb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [smbb_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [smbb_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            s_tuser;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [smbb_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tuser;
	logic                            m_tlast;
	int                              fail_count;
	int                              results_due;

	int   send_idle = 0;
	int   recv_idle = 0;
	int   beats_sent = 0;
	bit   written[smbb_pkg::BITMAP_BYTES_DEF];
	int   cur_sw = int'(smbb_pkg::RST_SOURCE_WIDTH);
	int   cur_sh = int'(smbb_pkg::RST_SOURCE_HEIGHT);
	int   cur_dw = int'(smbb_pkg::RST_DEST_WIDTH);
	int   cur_dh = int'(smbb_pkg::RST_DEST_HEIGHT);
	int   cur_fw = int'(smbb_pkg::RST_FRAME_WIDTH);
	int   cur_fh = int'(smbb_pkg::RST_FRAME_HEIGHT);
	event stall_kick;
	logic stall_all = 1'b0;

	scaled_mono_bitmap_blit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	blit_row_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.errors   (fail_count),
		.pending  (results_due)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		m_tready <= !stall_all && ($urandom_range(0, 99) >= recv_idle);

	// hold the output off for a long stretch
	initial begin
		forever begin
			@(stall_kick);
			@(posedge clk);
			stall_all <= 1'b1;
			repeat (400) @(posedge clk);
			stall_all <= 1'b0;
		end
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic send_beat(input logic mode, input logic [smbb_pkg::IN_DATA_W-1:0] payload);
		if (beats_sent < 130) begin
			send_idle = 37;
			recv_idle <= 67;
		end else if (beats_sent < 260) begin
			send_idle = 67;
			recv_idle <= 37;
		end else begin
			send_idle = 0;
			recv_idle <= 0;
		end
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= payload;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic load_byte(input int idx, input logic [7:0] val);
		logic [95:0]                    junk;
		logic [smbb_pkg::IN_DATA_W-1:0] payload;
		junk = {$urandom, $urandom, $urandom};
		payload = junk[smbb_pkg::IN_DATA_W-1:0];
		payload[smbb_pkg::IN_DATA_W-1:83] = '0;
		payload[8:0] = idx[8:0];
		payload[16:9] = val;
		written[idx] = 1'b1;
		send_beat(smbb_pkg::MODE_LOAD, payload);
	endtask

	// load any sampled byte that was never written, then send the render
	task automatic render_row(input int row, input int ox, input int oy,
			input logic [31:0] color);
		longint                         cols;
		longint                         xs;
		longint                         ys;
		longint                         sy;
		longint                         sx;
		longint                         b;
		logic [95:0]                    junk;
		logic [smbb_pkg::IN_DATA_W-1:0] payload;
		cols = (cur_dw > smbb_pkg::MAX_DEST_WIDTH_DEF) ? smbb_pkg::MAX_DEST_WIDTH_DEF : cur_dw;
		if (row < cur_dh && cols > 0) begin
			xs = ((longint'(cur_sw) << smbb_pkg::FRAC_W) / cur_dw) + 1;
			ys = ((longint'(cur_sh) << smbb_pkg::FRAC_W) / cur_dh) + 1;
			sy = (row * ys) >> smbb_pkg::FRAC_W;
			for (longint j = 0; j < cols; j++) begin
				sx = (j * xs) >> smbb_pkg::FRAC_W;
				b = (sy * cur_sw + sx) >> 3;
				if (b < smbb_pkg::BITMAP_BYTES_DEF && !written[b])
					load_byte(int'(b), 8'($urandom_range(0, 255)));
			end
		end
		junk = {$urandom, $urandom, $urandom};
		payload = junk[smbb_pkg::IN_DATA_W-1:0];
		payload[smbb_pkg::IN_DATA_W-1:83] = '0;
		payload[26:17] = row[9:0];
		payload[38:27] = ox[11:0];
		payload[50:39] = oy[11:0];
		payload[82:51] = color;
		send_beat(smbb_pkg::MODE_RENDER, payload);
	endtask

	task automatic write_config(input int sw, input int sh, input int dw, input int dh,
			input int fw, input int fh);
		int                             vals[6];
		logic [smbb_pkg::CFG_IDX_W-1:0] regs[6];
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		vals = '{sw, sh, dw, dh, fw, fh};
		regs = '{smbb_pkg::REG_SOURCE_WIDTH, smbb_pkg::REG_SOURCE_HEIGHT,
			smbb_pkg::REG_DEST_WIDTH, smbb_pkg::REG_DEST_HEIGHT,
			smbb_pkg::REG_FRAME_WIDTH, smbb_pkg::REG_FRAME_HEIGHT};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i][smbb_pkg::CFG_DATA_W-1:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_sw = sw;
		cur_sh = sh;
		cur_dw = dw;
		cur_dh = dh;
		cur_fw = fw;
		cur_fh = fh;
	endtask

	function automatic int pick_origin(input int extent);
		int span;
		span = (extent > 4096) ? 4096 : extent;
		if ($urandom_range(0, 1))
			return $urandom_range(0, 4095);
		return $urandom_range(0, span - 1);
	endfunction

	initial begin
		int phase;
		int ops;
		int pick;
		int rows_avail;
		int drain;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = smbb_pkg::MODE_LOAD;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 8x8 bitmap at reset sizes, edge patterns, clipping on both edges
		load_byte(0, 8'hFF);
		load_byte(1, 8'h00);
		load_byte(2, 8'h80);
		load_byte(3, 8'h01);
		load_byte(4, 8'hAA);
		load_byte(5, 8'h55);
		load_byte(6, 8'hC3);
		load_byte(7, 8'h3C);
		load_byte(511, 8'hFF);
		render_row(0, 0, 0, 32'hFFFF_FFFF);
		render_row(1, 4095, 0, $urandom);
		render_row(2, 636, 10, 32'h1234_5678);
		render_row(4, 636, 20, $urandom);
		render_row(7, 0, 4095, $urandom);
		render_row(5, 632, 474, $urandom);
		render_row(6, 632, 473, $urandom);
		render_row(8, 0, 0, $urandom);
		render_row(1023, 0, 0, $urandom);
		render_row(3, 0, 0, 32'h0000_0000);

		// largest sizes while the output is held off
		write_config(64, 64, 64, 1024, 4096, 4096);
		-> stall_kick;
		repeat (8)
			render_row($urandom_range(0, 1023), pick_origin(cur_fw), pick_origin(cur_fh), $urandom);

		phase = 0;
		while (beats_sent < 350) begin
			case (phase)
				0: write_config(1, 1, 1, 1, 1, 1);
				1: write_config(0, 0, 127, 2047, 8191, 8191);
				2: write_config(127, 127, 64, 1024, 300, 4096);
				3: write_config(5, 3, 0, 0, 100, 100);
				default: write_config($urandom_range(1, 64), $urandom_range(1, 64),
					($urandom_range(0, 3) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 16),
					($urandom_range(0, 2) == 0) ? $urandom_range(512, 1024) : $urandom_range(1, 64),
					$urandom_range(1, 4096), $urandom_range(1, 4096));
			endcase
			ops = $urandom_range(20, 40);
			repeat (ops) begin
				pick = $urandom_range(0, 9);
				rows_avail = (cur_dh > 1024) ? 1024 : cur_dh;
				if (pick == 0)
					load_byte($urandom_range(0, 511), 8'($urandom_range(0, 255)));
				else if (pick == 1 || rows_avail == 0)
					render_row($urandom_range(0, 1023), pick_origin(cur_fw),
						pick_origin(cur_fh), $urandom);
				else
					render_row($urandom_range(0, rows_avail - 1), pick_origin(cur_fw),
						pick_origin(cur_fh), $urandom);
			end
			phase++;
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		for (drain = 0; results_due != 0 && drain < 200000; drain++)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (results_due != 0)
			$display("%0t: %0d pixel beats never arrived", $time, results_due);
		if (fail_count == 0 && results_due == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
